>>> rtl/core/deq_pkg.sv
// deq_pkg: shared types and codes for the double-ended queue core
`timescale 1ns / 1ps

package deq_pkg;

    // fixed widths of the request and result fields
    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_READ       = 3'd4,
        REQ_WRITE      = 3'd5,
        REQ_CLEAR      = 3'd6
    } req_code_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_code_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DONE = 2'd2
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } deq_cmd_t;

endpackage

>>> rtl/core/deq_ram.sv
// deq_ram: generic single-port ram with registered read
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/deq_ctrl.sv
// deq_ctrl: request sequencer for the double-ended queue core
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output deq_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done       = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // result goes out while the next request may be taken
                done = 1'b1;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/deq_datapath.sv
// deq_datapath: ring pointers, range check and entry store of the queue
`timescale 1ns / 1ps

module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  deq_cmd_t                   cmd,
    input  logic [REQ_W-1:0]           req_type,
    input  logic [VALUE_W-1:0]         value,
    input  logic signed [INDEX_W-1:0]  index,
    output logic [STATUS_W-1:0]        status,
    output logic [VALUE_W-1:0]         read_data,
    output logic [COUNT_W-1:0]         entry_count,
    output logic                       is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int IW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;
    localparam int VW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    // captured request
    req_code_t                  req_reg;
    logic [DATA_WIDTH-1:0]      value_reg;
    logic signed [INDEX_W-1:0]  index_reg;

    // queue state
    logic [AW-1:0] front_reg;
    logic [AW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // result
    status_code_t status_reg;
    status_code_t status_next;
    logic         rd_ok_reg;
    logic         rd_ok_next;

    // ram port
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [DATA_WIDTH-1:0] ram_q;

    // decoded conditions
    logic                 is_full;
    logic                 is_zero;
    logic [SW-1:0]        back_sum;
    logic [AW-1:0]        back_slot;
    logic [AW-1:0]        front_dec;
    logic [AW-1:0]        front_inc;
    logic signed [IW-1:0] pos_s;
    logic signed [IW-1:0] cnt_s;
    logic                 in_range;
    logic signed [IW-1:0] offset_s;
    logic [SW-1:0]        loc_sum;
    logic [AW-1:0]        loc_slot;
    logic [VW-1:0]        value_ext;
    logic [VW-1:0]        rdata_ext;

    // request capture on transfer
    assign value_ext = VW'(value);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_code_t'(req_type);
            value_reg <= value_ext[DATA_WIDTH-1:0];
            index_reg <= index;
        end
    end

    // ring arithmetic
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_zero   = (count_reg == '0);
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                 : back_sum[AW-1:0];
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);

    // signed position check and slot lookup
    assign pos_s    = IW'(index_reg);
    assign cnt_s    = $signed(IW'(count_reg));
    assign in_range = (pos_s < cnt_s) && (pos_s >= -cnt_s);
    assign offset_s = (pos_s >= 0) ? pos_s : cnt_s + pos_s;
    assign loc_sum  = SW'(front_reg) + SW'(offset_s[AW-1:0]);
    assign loc_slot = (loc_sum >= SW'(DEPTH)) ? AW'(loc_sum - SW'(DEPTH))
                                               : loc_sum[AW-1:0];

    // operation decode
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        rd_ok_next  = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = loc_slot;
        case (req_reg)
            REQ_PUSH_BACK:
            begin
                ram_addr = back_slot;
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            REQ_PUSH_FRONT:
            begin
                ram_addr = front_dec;
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            REQ_POP_BACK:
            begin
                if (is_zero)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            REQ_POP_FRONT:
            begin
                if (is_zero)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            REQ_READ:
            begin
                if (in_range)
                begin
                    rd_ok_next = 1'b1;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            REQ_WRITE:
            begin
                if (in_range)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            REQ_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            default:
            begin
                // unused code leaves the queue as it is and reports ST_OK
            end
        endcase
    end

    // queue state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            rd_ok_reg  <= rd_ok_next;
        end
    end

    // entry store
    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (cmd.exec),
        .we    (cmd.exec & ram_we),
        .addr  (ram_addr),
        .wdata (value_reg),
        .rdata (ram_q)
    );

    // result outputs
    assign rdata_ext   = VW'(ram_q);
    assign status      = status_reg;
    assign read_data   = rd_ok_reg ? rdata_ext[VALUE_W-1:0] : '0;
    assign entry_count = COUNT_W'(count_reg);
    assign is_empty    = is_zero;

endmodule

>>> rtl/core/double_ended_queue_core.sv
// double_ended_queue_core: bounded double-ended queue over a ring store
// sequence: a request is captured on transfer, executed in the exec state
// and reported in the done state; a new request is taken in idle or done,
//   not in exec (exec accesses the single store port, done shows its read)
// reset: queue empty and front slot zero at once; store contents undefined
// the receiver cannot stall: done marks each result for one cycle
`timescale 1ns / 1ps

module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [REQ_W-1:0]          req_type,
    input  logic [VALUE_W-1:0]        value,
    input  logic signed [INDEX_W-1:0] index,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic [VALUE_W-1:0]        read_data,
    output logic [COUNT_W-1:0]        entry_count,
    output logic                      is_empty
);

    deq_cmd_t cmd;

    // sequencer
    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // queue datapath
    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .value       (value),
        .index       (index),
        .status      (status),
        .read_data   (read_data),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

endmodule
